[src/c3x3_pkg.sv]
// Shared types and constants for the 3x3 zero-padded convolution filter.
// Used by the channel interfaces, the line store and the top level; no dependencies.

package c3x3_pkg;

    localparam int PIXEL_W      = 8;
    localparam int VALUE_W      = 28;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_INDEX_W  = 3;
    localparam int DIM_REG_W    = 11;
    localparam int DIM_RESET    = 1024;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;
    localparam int DEFAULT_COEF_BITS  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_WIDTH       = 3'd3,
        CFG_HEIGHT      = 3'd4
    } cfg_reg_t;

    // Where the output position sits against the image border.
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
    } border_t;

endpackage

[src/c3x3_if.sv]
// Valid/ready channel interfaces for the pixel input and the filtered result output.
// Depends on c3x3_pkg for the field widths.

interface c3x3_pixel_if import c3x3_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               drain;

    modport source (output valid, output pixel, output drain, input ready);
    modport sink   (input valid, input pixel, input drain, output ready);
endinterface

interface c3x3_result_if import c3x3_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] filtered_value;
    logic                      end_of_row;
    logic                      end_of_frame;

    modport source (output valid, output filtered_value, output end_of_row,
                    output end_of_frame, input ready);
    modport sink   (input valid, input filtered_value, input end_of_row,
                    input end_of_frame, output ready);
endinterface

[src/c3x3_line_store.sv]
// Two-row line store: one memory word per column holds the pixels of the two rows above.
// Clears itself after reset, reads with a registered port and bypasses a same-cycle write.

module c3x3_line_store
    import c3x3_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [2*PIXEL_W-1:0]       rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*PIXEL_W-1:0]       wr_data,
    output logic                       busy
);

    localparam int AW = $clog2(DEPTH);

    logic [2*PIXEL_W-1:0] mem [DEPTH];

    logic                 clr_active_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [2*PIXEL_W-1:0] rd_q_reg;
    logic                 byp_hit_reg;
    logic [2*PIXEL_W-1:0] byp_data_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [2*PIXEL_W-1:0] mem_wdata;

    // The clearing pass owns the write port until every column is zero.
    always_comb
    begin
        mem_we    = clr_active_reg || wr_en;
        mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_active_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (rd_en)
            begin
                byp_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_q_reg;
    assign busy    = clr_active_reg;

endmodule

[src/conv3x3_zero_padded_filter.sv]
// Top level of the 3x3 zero-padded convolution filter over a raster pixel stream.
// Depends on c3x3_pkg, the channel interfaces in c3x3_if.sv and c3x3_line_store.
//
// Usage. Pixels enter on the valid/ready channel "pixels" in raster order, one beat per
// pixel. Each beat whose drain bit is set stands for a padding pixel of value zero. After
// the last pixel of a frame the host sends image_width + 1 drain beats, which push out the
// remaining results. Every beat from the (image_width + 2)-th of a frame onwards yields one
// result beat on "results": the signed sum of the nine coefficient-times-neighbour
// products, with end_of_row and end_of_frame marking the last result of a row and of the
// image. After the end_of_frame result the next beat starts a new frame.
// Throughput is one pixel per clock unless the receiver stalls or the store is clearing.
// A result passes from the beat that releases it through the line store read, the window
// shift and the output register; the nine products are summed on the way into that register.
// Coefficients and image size are written through the plain write port (cfg_write,
// cfg_index, cfg_data) while the block is idle; writes are always taken.
// After reset the line store is cleared, one column a cycle, so pixels.ready stays low
// until every column is zero. When the receiver stalls, the output register holds its
// beat and the whole pipeline freezes with it, so pixels.ready falls in the same cycle.

module conv3x3_zero_padded_filter
    import c3x3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
    parameter int COEF_BITS  = DEFAULT_COEF_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    c3x3_pixel_if.sink             pixels,
    c3x3_result_if.source          results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Column counters index the line store; the row counters must survive a frame
    // whose width was changed under way, so the input row has headroom and saturates.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HD_W    = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + MAX_WIDTH + 2) + 1;
    localparam int CW3     = 3 * COEF_BITS;
    localparam int PROD_W  = COEF_BITS + PIXEL_W + 1;
    localparam int SUM_W   = PROD_W + 4;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] coef_reg [3];
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;

    // Position counters, all advanced when a beat is accepted.
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    // Second stage: line store data arrives, the window shifts.
    logic                 b_valid_reg;
    logic                 b_emit_reg;
    logic [PIXEL_W-1:0]   b_x_reg;
    logic [COL_W-1:0]     b_col_reg;
    border_t              b_border_reg;
    logic [PIXEL_W-1:0]   win_reg [3][3];

    // Third stage: the window is complete and the sum goes to the output register.
    logic                 c_valid_reg;
    border_t              c_border_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_eor_reg;
    logic                      out_eof_reg;

    logic               advance;
    logic               accept;
    logic               ls_busy;
    logic [2*PIXEL_W-1:0] ls_rd_data;
    logic [PIXEL_W-1:0] above;
    logic [PIXEL_W-1:0] above2;

    logic [WD_W-1:0]    w_eff;
    logic [HD_W-1:0]    h_eff;
    logic [PIXEL_W-1:0] x_in;
    logic               emit;
    logic               col_wrap;
    logic               last_col;
    logic               last_row;
    border_t            border_in;

    logic [CW3-1:0]             coef_ext [3];
    logic signed [PROD_W-1:0]   prod [3][3];
    logic                       tap_on [3][3];
    logic signed [SUM_W-1:0]    sum;

    // The whole pipeline moves whenever the output register is free or being emptied.
    assign advance       = !out_valid_reg || results.ready;
    assign pixels.ready  = advance && !ls_busy;
    assign accept        = pixels.valid && pixels.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            width_reg   <= DIM_REG_W'(DIM_RESET);
            height_reg  <= DIM_REG_W'(DIM_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_COEF_TOP:    coef_reg[0] <= cfg_data;
                CFG_COEF_MIDDLE: coef_reg[1] <= cfg_data;
                CFG_COEF_BOTTOM: coef_reg[2] <= cfg_data;
                CFG_WIDTH:       width_reg   <= cfg_data[DIM_REG_W-1:0];
                CFG_HEIGHT:      height_reg  <= cfg_data[DIM_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    // A size of zero acts as one, a size above the build maximum acts as that maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WD_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WD_W'(MAX_WIDTH);
        else
            w_eff = WD_W'(width_reg);

        if (height_reg == '0)
            h_eff = HD_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = HD_W'(MAX_HEIGHT);
        else
            h_eff = HD_W'(height_reg);
    end

    // Counter logic for the accepted beat. Rows below the image are padding, so a pixel
    // there counts as a zero just like a drain beat.
    always_comb
    begin
        x_in     = (!pixels.drain && (int'(in_row_reg) < int'(h_eff))) ? pixels.pixel : '0;
        emit     = (int'(in_row_reg) >= 2) || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        col_wrap = (int'(in_col_reg) + 1) >= int'(w_eff);
        last_col = (int'(out_col_reg) + 1) >= int'(w_eff);
        last_row = (int'(out_row_reg) + 1) >= int'(h_eff);

        border_in.first_col = (out_col_reg == '0);
        border_in.last_col  = last_col;
        border_in.first_row = (out_row_reg == '0);
        border_in.last_row  = last_row;

        if (col_wrap)
        begin
            in_col_next = '0;
            in_row_next = (in_row_reg == ROW_MAX) ? in_row_reg : in_row_reg + 1'b1;
        end
        else
        begin
            in_col_next = in_col_reg + 1'b1;
            in_row_next = in_row_reg;
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (last_col)
            begin
                out_col_next = '0;
                if (last_row)
                begin
                    // The last result of the frame: everything starts over.
                    out_row_next = '0;
                    in_col_next  = '0;
                    in_row_next  = '0;
                end
                else
                begin
                    out_row_next = out_row_reg + 1'b1;
                end
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    c3x3_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (b_valid_reg && advance),
        .wr_addr (b_col_reg),
        .wr_data ({above, b_x_reg}),
        .busy    (ls_busy)
    );

    // The upper byte of a line store word is two rows up, the lower byte one row up.
    assign above2 = ls_rd_data[2*PIXEL_W-1:PIXEL_W];
    assign above  = ls_rd_data[PIXEL_W-1:0];

    // Products with the coefficients, masked where the neighbour lies outside the image.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coef_ext[i] = CW3'(coef_reg[i]);
            for (int j = 0; j < 3; j++)
            begin
                tap_on[i][j] = !((i == 0 && c_border_reg.first_row) ||
                                 (i == 2 && c_border_reg.last_row)  ||
                                 (j == 0 && c_border_reg.first_col) ||
                                 (j == 2 && c_border_reg.last_col));
                prod[i][j] = $signed(coef_ext[i][j*COEF_BITS +: COEF_BITS])
                             * $signed({1'b0, win_reg[i][j]});
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (tap_on[i][j])
                begin
                    sum = sum + prod[i][j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            b_valid_reg   <= 1'b0;
            b_emit_reg    <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (advance)
        begin
            if (accept)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
            b_valid_reg   <= accept;
            b_emit_reg    <= accept && emit;
            c_valid_reg   <= b_valid_reg && b_emit_reg;
            out_valid_reg <= c_valid_reg;
            if (b_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= above2;
                win_reg[1][2] <= above;
                win_reg[2][2] <= b_x_reg;
            end
        end
    end

    // Payload registers follow their valid flags and need no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                b_x_reg      <= x_in;
                b_col_reg    <= in_col_reg;
                b_border_reg <= border_in;
            end
            c_border_reg  <= b_border_reg;
            out_value_reg <= VALUE_W'(sum);
            out_eor_reg   <= c_border_reg.last_col;
            out_eof_reg   <= c_border_reg.last_col && c_border_reg.last_row;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.filtered_value = out_value_reg;
    assign results.end_of_row     = out_eor_reg;
    assign results.end_of_frame   = out_eof_reg;

`ifndef ASSERT_OFF
    // Nothing may enter the pipeline while the line store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        ls_busy |-> !b_valid_reg && !c_valid_reg)
        else $error("pipeline holds a beat during the line store clearing pass");

    // A frame's last result returns every position counter to the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && last_col && last_row) |=>
            (in_col_reg == '0) && (in_row_reg == '0) &&
            (out_col_reg == '0) && (out_row_reg == '0))
        else $error("position counters not cleared at the end of a frame");

    // A result only appears after the sum stage held a valid beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(c_valid_reg))
        else $error("result appeared without a beat in the sum stage");

    // The end of the frame is always also the end of a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eof_reg) |-> out_eor_reg)
        else $error("end_of_frame without end_of_row");
`endif

endmodule

[sim/tb_conv3x3_zero_padded_filter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_zero_padded_filter: directed frames, then random frames.
// Depends on c3x3_pkg, the channel interfaces in c3x3_if.sv and the filter RTL.

module tb_conv3x3_zero_padded_filter;
    import c3x3_pkg::*;

    localparam int MAX_W        = DEFAULT_MAX_WIDTH;
    localparam int MAX_H        = DEFAULT_MAX_HEIGHT;
    localparam int COEF_W       = DEFAULT_COEF_BITS;
    localparam int ROW_CAP      = 4095;
    // The filter holds a beat in three register stages; this pause is longer than that.
    localparam int SETTLE_GAP   = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_BEATS = 540;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 400;
    // No beat on either channel for this many cycles means the run has hung. The longest
    // legitimate quiet spells are the line store clearing after reset and the long hold.
    localparam int STALL_LIMIT  = 6000;
    localparam int MAX_REPORTS  = 40;

    localparam logic [CFG_DATA_W-1:0] MIN_COEFS = 48'h8000_8000_8000;
    localparam logic [CFG_DATA_W-1:0] MAX_COEFS = 48'h7FFF_7FFF_7FFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      eor;
        logic                      eof;
    } result_t;

    typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_t;

    // One row of the directed plan: either a register write or one input beat. Where the
    // result that the beat releases is obvious by hand, it is typed in and checked as is.
    typedef struct {
        row_kind_t             kind;
        cfg_reg_t              target;
        logic [CFG_DATA_W-1:0] data;
        logic [PIXEL_W-1:0]    px;
        logic                  drn;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    c3x3_pixel_if  pix_ch();
    c3x3_result_if res_ch();

    conv3x3_zero_padded_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Frame A: 3x3 of full-scale pixels under the most negative coefficients, so the centre
    // sums nine equal products and the bottom-right corner four of them.
    // Frame B: 2x2 under the most positive coefficients; its first beat is a drain inside
    // the frame, and a plain pixel sent after the frame's last pixel must be ignored.
    plan_row_t directed_plan [0:29] = '{
        '{ROW_CFG,  CFG_COEF_TOP,    MIN_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_COEF_MIDDLE, MIN_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_COEF_BOTTOM, MIN_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_WIDTH,       48'd3,     8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HEIGHT,      48'd3,     8'h00, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b1,
          '{-28'sd75202560, 1'b0, 1'b0}},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b1,
          '{-28'sd33423360, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_COEF_TOP,    MAX_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_COEF_MIDDLE, MAX_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_COEF_BOTTOM, MAX_COEFS, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_WIDTH,       48'd2,     8'h00, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HEIGHT,      48'd2,     8'h00, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b1, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'hFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h80, 1'b0, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b0, '0},
        '{ROW_BEAT, CFG_COEF_TOP,    '0,        8'h00, 1'b1, 1'b1,
          '{28'sd16711170, 1'b1, 1'b1}}
    };

    // Shadow of the filter: registers, line store, window and raster counters.
    logic [CFG_DATA_W-1:0] coef_rows [0:2];
    logic [DIM_REG_W-1:0]  width_reg;
    logic [DIM_REG_W-1:0]  height_reg;
    logic [PIXEL_W-1:0]    line_mem [0:2*MAX_W-1];
    logic [PIXEL_W-1:0]    win [0:2][0:2];
    int unsigned           in_col, in_row, out_col, out_row;
    bit                    frame_closed;

    result_t expected_results [$];
    int      mismatches;
    int      results_seen;
    int      beats_sent;
    int      burst_left;
    int      quiet_cycles;
    bit      hold_done;

    always #2 clk = ~clk;

    function automatic int unsigned clamp_dim(logic [DIM_REG_W-1:0] v, int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    function automatic longint coef_of(int r, int c);
        logic signed [COEF_W-1:0] k;
        k = coef_rows[r][c*COEF_W +: COEF_W];
        return longint'(k);
    endfunction

    function automatic int frame_pixels();
        return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Three packed coefficients: fully random, or slots chosen among the two extremes and
    // small signed values so that sums near the ends of the output range turn up.
    function automatic logic [CFG_DATA_W-1:0] rand_coefs();
        logic [CFG_DATA_W-1:0] row;
        int                    k;
        row[31:0]  = $urandom;
        row[47:32] = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 2) != 0)
        begin
            for (k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       row[k*COEF_W +: COEF_W] = 16'h8000;
                    1:       row[k*COEF_W +: COEF_W] = 16'h7FFF;
                    2:       row[k*COEF_W +: COEF_W] = 16'($urandom_range(0, 15)) - 16'd8;
                    default: ;
                endcase
            end
        end
        return row;
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_REG_W'($urandom_range(9, 40));
            default: return DIM_REG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_height();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_REG_W'($urandom_range(10, 16));
            default: return DIM_REG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Advances the shadow by one accepted input beat and yields the result it releases.
    // The result for raster position q leaves on beat q + width + 1 of the frame, so the
    // window then holds that position's neighbourhood; borders are masked, not read.
    task automatic convolve_beat(input logic [PIXEL_W-1:0] px, input logic drn,
                                 output bit produced, output result_t res);
        int unsigned        w, h, c, r, ci, oc, orow;
        logic [PIXEL_W-1:0] x, up, up2;
        bit                 last_c, last_r;
        longint             acc;
        int                 i, j;
        w   = clamp_dim(width_reg, MAX_W);
        h   = clamp_dim(height_reg, MAX_H);
        c   = in_col;
        r   = in_row;
        ci  = (c < MAX_W) ? c : MAX_W - 1;
        x   = (!drn && r < h) ? px : '0;
        up2 = line_mem[MAX_W + ci];
        up  = line_mem[ci];
        line_mem[MAX_W + ci] = up;
        line_mem[ci]         = x;
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up;
        win[2][2] = x;
        produced = (r >= 2) || (r == 1 && c >= 1);
        if (c + 1 >= w)
        begin
            in_col = 0;
            if (in_row < ROW_CAP)
                in_row++;
        end
        else
        begin
            in_col = c + 1;
        end
        res = '0;
        if (produced)
        begin
            oc     = out_col;
            orow   = out_row;
            last_c = (oc + 1 >= w);
            last_r = (orow + 1 >= h);
            acc    = 0;
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    if ((i == 0 && orow == 0) || (i == 2 && last_r) ||
                        (j == 0 && oc == 0) || (j == 2 && last_c))
                        continue;
                    acc += coef_of(i, j) * longint'(win[i][j]);
                end
            end
            res.value = acc[VALUE_W-1:0];
            res.eor   = last_c;
            res.eof   = last_c && last_r;
            if (last_c)
            begin
                out_col = 0;
                if (last_r)
                begin
                    // Frame complete: every counter starts over, the stores keep their data.
                    out_row      = 0;
                    in_col       = 0;
                    in_row       = 0;
                    frame_closed = 1'b1;
                end
                else
                begin
                    out_row = orow + 1;
                end
            end
            else
            begin
                out_col = oc + 1;
            end
        end
    endtask

    // Offers one beat and waits for it to be taken. The sender works in bursts: when one
    // ends, valid may drop for a random gap before the next burst starts. A few bursts are
    // long so that there are stretches at full rate.
    task automatic offer(input logic [PIXEL_W-1:0] px, input logic drn,
                         input bit typed, input result_t want);
        int      gap;
        bit      produced;
        result_t got;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(10, 30);
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        pix_ch.drain <= drn;
        do
            @(posedge clk);
        while (!(pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1));
        beats_sent++;
        convolve_beat(px, drn, produced, got);
        if (produced)
            expected_results.push_back(typed ? want : got);
    endtask

    // Brings the block to rest: no beat offered, every result delivered, and a pause for beats
    // that released nothing but may still be in the pipeline.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // One register write; cfg_write stays high so that writes can follow back to back.
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        case (sel)
            CFG_COEF_TOP:    coef_rows[0] = val;
            CFG_COEF_MIDDLE: coef_rows[1] = val;
            CFG_COEF_BOTTOM: coef_rows[2] = val;
            CFG_WIDTH:       width_reg    = val[DIM_REG_W-1:0];
            CFG_HEIGHT:      height_reg   = val[DIM_REG_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] top, mid, bot,
                             input logic [DIM_REG_W-1:0] w, h);
        settle();
        write_reg(CFG_COEF_TOP, top);
        write_reg(CFG_COEF_MIDDLE, mid);
        write_reg(CFG_COEF_BOTTOM, bot);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        cfg_write <= 1'b0;
    endtask

    // Pixels of a frame, with the odd drain beat inside the frame standing in for a zero.
    task automatic send_pixels(input int n, input int drain_pct);
        frame_closed = 1'b0;
        repeat (n)
            offer(pick_pixel(), ($urandom_range(0, 99) < drain_pct), 1'b0, '0);
    endtask

    // Padding beats until the end-of-frame result has been released. Some of them are
    // plain pixels, which the block must treat as padding once the frame is complete.
    task automatic finish_frame(input int stray_pct);
        while (!frame_closed)
            offer(pick_pixel(), ($urandom_range(0, 99) >= stray_pct), 1'b0, '0);
    endtask

    // Results are checked in order against the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat: value %0d eor %b eof %b", $time,
                             res_ch.filtered_value, res_ch.end_of_row, res_ch.end_of_frame);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.filtered_value !== want.value)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: filtered_value expected %0d, got %0d", $time,
                                 want.value, res_ch.filtered_value);
                end
                if (res_ch.end_of_row !== want.eor)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: end_of_row expected %b, got %b", $time,
                                 want.eor, res_ch.end_of_row);
                end
                if (res_ch.end_of_frame !== want.eof)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: end_of_frame expected %b, got %b", $time,
                                 want.eof, res_ch.end_of_frame);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: ready follows a mode redrawn after each run of random length. Once, after a
    // number of results and while a beat is on offer, it holds off for a long stretch as
    // the sender keeps offering, so the pipeline fills and the block has to stall its input.
    initial
    begin : receiver
        rx_mode_t mode;
        int       len;
        int       tick;
        tick = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(40, 200);
            repeat (len)
            begin
                @(posedge clk);
                tick++;
                if (!hold_done && results_seen >= HOLD_AFTER && pix_ch.valid === 1'b1)
                begin
                    hold_done = 1'b1;
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    RX_ALWAYS:      res_ch.ready <= 1'b1;
                    RX_COIN:        res_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY:      res_ch.ready <= ($urandom_range(0, 7) != 0);
                    RX_EVERY_THIRD: res_ch.ready <= ((tick % 3) != 0);
                    default:        res_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int start_beats;
        bit writing;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_COEF_TOP;
        cfg_data     = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        pix_ch.drain = 1'b0;
        res_ch.ready = 1'b0;

        // Shadow state after reset.
        coef_rows[0] = '0;
        coef_rows[1] = '0;
        coef_rows[2] = '0;
        width_reg    = DIM_REG_W'(DIM_RESET);
        height_reg   = DIM_REG_W'(DIM_RESET);
        foreach (line_mem[k])
            line_mem[k] = '0;
        foreach (win[a, b])
            win[a][b] = '0;
        in_col       = 0;
        in_row       = 0;
        out_col      = 0;
        out_row      = 0;
        frame_closed = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        beats_sent   = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        hold_done    = 1'b0;
        writing      = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed plan. A run of register writes starts only once the block is at rest.
        for (i = 0; i < $size(directed_plan); i++)
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                if (!writing)
                    settle();
                writing = 1'b1;
                write_reg(directed_plan[i].target, directed_plan[i].data);
            end
            else
            begin
                if (writing)
                begin
                    cfg_write <= 1'b0;
                    writing = 1'b0;
                end
                offer(directed_plan[i].px, directed_plan[i].drn,
                      directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // Size extremes: zero acts as one in both dimensions. An over-range size is taken
        // in and a few beats are sent under it; then, with the pipeline drained, it is cut
        // back so that the frame closes after a handful of beats.
        configure(rand_coefs(), rand_coefs(), rand_coefs(), 11'd0, 11'd3);
        send_pixels(frame_pixels(), 3);
        finish_frame(20);
        configure(rand_coefs(), rand_coefs(), rand_coefs(), 11'd4, 11'd0);
        send_pixels(frame_pixels(), 3);
        finish_frame(20);
        configure(rand_coefs(), rand_coefs(), rand_coefs(), 11'd2047, 11'd2);
        send_pixels(6, 3);
        settle();
        write_reg(CFG_WIDTH, CFG_DATA_W'(3));
        cfg_write <= 1'b0;
        finish_frame(20);
        configure(rand_coefs(), rand_coefs(), rand_coefs(), 11'd2, 11'd2047);
        send_pixels(6, 3);
        settle();
        write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
        cfg_write <= 1'b0;
        finish_frame(20);

        // Size change in the middle of a frame: with the pipeline drained, the image is
        // made narrower and shorter, so counters already past the new size wrap at once.
        configure(rand_coefs(), rand_coefs(), rand_coefs(), 11'd6, 11'd5);
        send_pixels(17, 0);
        settle();
        write_reg(CFG_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(3));
        cfg_write <= 1'b0;
        finish_frame(20);

        // Random frames: mostly small images with random content and coefficients.
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            configure(rand_coefs(), rand_coefs(), rand_coefs(), pick_width(), pick_height());
            send_pixels(frame_pixels(), 6);
            finish_frame($urandom_range(0, 40));
        end

        pix_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
src/c3x3_pkg.sv
src/c3x3_if.sv
src/c3x3_line_store.sv
src/conv3x3_zero_padded_filter.sv
sim/tb_conv3x3_zero_padded_filter.sv
